### hdl/plca_pkg.sv
// shared constants, types and timeout functions of the plca timer bank
package plca_pkg;

  // bank geometry
  localparam int STATIONS    = 8;
  localparam int NUM_TIMERS  = 12;
  localparam int COUNT_WIDTH = 24;

  // field widths
  localparam int CMD_W     = 3;
  localparam int ST_W      = 4;
  localparam int ID_W      = 4;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int TO_W      = 24;
  localparam int STB_W     = 14;

  // address widths into the store and into one station word
  localparam int ST_AW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int TM_AW = $clog2(NUM_TIMERS);

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START_DONE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TPUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPBIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODES = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] TPUS_RST  = 8'd10;
  localparam logic [CFG_W-1:0] TPBIT_RST = 8'd1;
  localparam logic [CFG_W-1:0] NODES_RST = 8'd8;

  // timer ids
  localparam int TMR_MAX        = 0;
  localparam int TMR_UNJAB      = 1;
  localparam int TMR_STD        = 2;
  localparam int TMR_RSCD       = 3;
  localparam int TMR_BEACON     = 4;
  localparam int TMR_BEACON_DET = 5;
  localparam int TMR_INV_BEACON = 6;
  localparam int TMR_BURST      = 7;
  localparam int TMR_TO         = 8;
  localparam int TMR_COMMIT     = 9;
  localparam int TMR_PENDING    = 10;
  localparam int TMR_STATUS     = 11;

  typedef logic [COUNT_WIDTH-1:0]                 count_t;
  typedef logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] word_t;
  typedef logic [NUM_TIMERS-1:0][TO_W-1:0]        tov_t;

  typedef struct packed {
    logic ok;
    logic done_res;
  } result_t;

  // status timer length in bit times: 2*(24*nodes+20)
  function automatic logic [STB_W-1:0] status_bits(input logic [CFG_W-1:0] nodes);
    return STB_W'(48 * int'(nodes) + 40);
  endfunction

  // timeout of one timer in ticks
  function automatic logic [TO_W-1:0] timeout_of(input int id,
                                                 input logic [CFG_W-1:0] us,
                                                 input logic [CFG_W-1:0] bt,
                                                 input logic [STB_W-1:0] stb);
    logic [TO_W-1:0] us_w;
    logic [TO_W-1:0] bt_w;
    us_w = TO_W'(us);
    bt_w = TO_W'(bt);
    case (id)
      TMR_MAX:        return us_w * TO_W'(2000);
      TMR_UNJAB:      return us_w * TO_W'(16000);
      TMR_STD:        return bt_w * TO_W'(4);
      TMR_RSCD:       return bt_w * TO_W'(4);
      TMR_BEACON:     return bt_w * TO_W'(20);
      TMR_BEACON_DET: return bt_w * TO_W'(22);
      TMR_INV_BEACON: return us_w * TO_W'(4);
      TMR_BURST:      return bt_w * TO_W'(128);
      TMR_TO:         return bt_w * TO_W'(24);
      TMR_COMMIT:     return bt_w * TO_W'(288);
      TMR_PENDING:    return bt_w * TO_W'(512);
      TMR_STATUS:     return TO_W'(stb) * bt_w;
      default:        return '0;
    endcase
  endfunction

endpackage

### hdl/plca_in_if.sv
// command channel of the plca timer bank
interface plca_in_if import plca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ST_W-1:0]  station;
  logic [ID_W-1:0]  timer_id;

  modport source(output valid, command, station, timer_id, input ready);
  modport sink(input valid, command, station, timer_id, output ready);
endinterface

### hdl/plca_out_if.sv
// result channel of the plca timer bank
interface plca_out_if import plca_pkg::*; ();
  logic valid;
  logic ready;
  logic ok;
  logic done_res;

  modport source(output valid, ok, done_res, input ready);
  modport sink(input valid, ok, done_res, output ready);
endinterface

### hdl/plca_cfg_if.sv
// register write channel of the plca timer bank
interface plca_cfg_if import plca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [CFG_W-1:0]     data;

  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

### hdl/plca_cfg_regs.sv
// configuration registers and per-timer timeout values
module plca_cfg_regs import plca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  plca_cfg_if.sink   cfg_ch,
  output tov_t       timeouts
);

  logic [CFG_W-1:0] tpus_r, tpus_nxt;
  logic [CFG_W-1:0] tpbit_r, tpbit_nxt;
  logic [STB_W-1:0] stb_r, stb_nxt;
  logic             wr;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  // register write decode, status length kept ready-made
  always_comb begin
    tpus_nxt  = tpus_r;
    tpbit_nxt = tpbit_r;
    stb_nxt   = stb_r;
    if (wr) begin
      case (cfg_ch.idx)
        REG_TPUS:  tpus_nxt  = cfg_ch.data;
        REG_TPBIT: tpbit_nxt = cfg_ch.data;
        REG_NODES: stb_nxt   = status_bits(cfg_ch.data);
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpus_r  <= TPUS_RST;
      tpbit_r <= TPBIT_RST;
      stb_r   <= status_bits(NODES_RST);
    end else begin
      tpus_r  <= tpus_nxt;
      tpbit_r <= tpbit_nxt;
      stb_r   <= stb_nxt;
    end
  end

  // one timeout per timer, follows the registers at once
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_to
    assign timeouts[i] = timeout_of(i, tpus_r, tpbit_r, stb_r);
  end

endmodule

### hdl/plca_cnt_ram.sv
// counter store: one word of all timers per station, cleared by valid flags
module plca_cnt_ram import plca_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [ST_AW-1:0] rd_addr,
  output word_t            rd_data,
  input  logic             wr_en,
  input  logic [ST_AW-1:0] wr_addr,
  input  word_t            wr_data
);

  word_t               mem [STATIONS];
  logic [STATIONS-1:0] valid_r;
  word_t               rdata_r;
  logic                rvalid_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // per-station valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      rvalid_r <= valid_r[rd_addr];
    end
  end

  // a word never written reads as all stopped
  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

### hdl/plca_timer_update.sv
// command decode and new counter word for one station
module plca_timer_update import plca_pkg::*; (
  input  logic [CMD_W-1:0] cmd,
  input  logic [ST_W-1:0]  st,
  input  logic [ID_W-1:0]  id,
  input  word_t            cur,
  input  tov_t             timeouts,
  output word_t            nxt,
  output logic             wr_en,
  output result_t          res
);

  word_t  tick_word;
  logic   st_ok;
  logic   id_ok;
  count_t sel_to;
  count_t sel_cnt;

  assign st_ok = (32'(st) < STATIONS);
  assign id_ok = (32'(id) < NUM_TIMERS);

  // tick: every running counter at or below its timeout advances
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_tick
    count_t to_c;
    logic   run;
    assign to_c = COUNT_WIDTH'(timeouts[i]);
    assign run  = (cur[i] != '0) && (cur[i] <= to_c);
    assign tick_word[i] = run ? cur[i] + 1'b1 : cur[i];
  end

  // addressed timer
  always_comb begin
    sel_to  = '0;
    sel_cnt = '0;
    if (id_ok) begin
      sel_to  = COUNT_WIDTH'(timeouts[id[TM_AW-1:0]]);
      sel_cnt = cur[id[TM_AW-1:0]];
    end
  end

  // command decode
  always_comb begin
    nxt          = cur;
    wr_en        = 1'b0;
    res.ok       = 1'b0;
    res.done_res = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (st_ok) begin
          nxt    = tick_word;
          wr_en  = 1'b1;
          res.ok = 1'b1;
        end
      end
      CMD_START: begin
        if (st_ok && id_ok && sel_to != '0) begin
          nxt[id[TM_AW-1:0]] = count_t'(1);
          wr_en  = 1'b1;
          res.ok = 1'b1;
        end
      end
      CMD_START_DONE: begin
        if (st_ok && id_ok && sel_to != '0) begin
          nxt[id[TM_AW-1:0]] = sel_to + 1'b1;
          wr_en  = 1'b1;
          res.ok = 1'b1;
        end
      end
      CMD_STOP: begin
        if (st_ok && id_ok) begin
          nxt[id[TM_AW-1:0]] = '0;
          wr_en  = 1'b1;
          res.ok = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (st_ok && id_ok) begin
          res.ok       = 1'b1;
          res.done_res = (sel_to != '0) && (sel_cnt > sel_to);
        end
      end
      default: ;
    endcase
  end

endmodule

### hdl/plca_timer_bank.sv
// top level of the plca timer bank: control, store and result register
//
// Twelve timers per station, one word of counters per station in a
// synchronous store. Commands arrive on in_ch (valid/ready): tick a
// station, start a timer from one or as already done, stop it, or ask
// whether it is done. Each command gives exactly one result item on
// out_ch: ok and done_res.
// Registers ticks_per_us, ticks_per_bit and node_count are written on
// cfg_ch, which is always ready; timeouts follow them at once.
// Timing: an accepted item starts the registered station word read;
// in the execute step that follows, the word is modified, and once the
// result slot is free it is written back and the result is loaded,
// which raises out_ch.valid. A new item is taken only once the last has
// left execute, set by the store's read latency and its read-modify-write.
// Reset: registers take their defaults and every station word reads as
// all stopped right away (per-station valid flags, no clearing pass).
// Stall: a result waits in the output register; the item behind it waits
// in the execute step and in_ch.ready stays low until the slot frees.
module plca_timer_bank import plca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  plca_in_if.sink    in_ch,
  plca_out_if.source out_ch,
  plca_cfg_if.sink   cfg_ch
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r;
  logic [CMD_W-1:0] cmd_r;
  logic [ST_W-1:0]  st_r;
  logic [ID_W-1:0]  id_r;

  logic             accept;
  logic             adv;
  tov_t             timeouts;
  word_t            cur_word;
  word_t            new_word;
  logic             upd_wr;
  result_t          upd_res;
  logic             mem_wr;

  // registers and timeouts
  plca_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .timeouts (timeouts)
  );

  // station word store
  plca_cnt_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && (32'(in_ch.station) < STATIONS)),
    .rd_addr (in_ch.station[ST_AW-1:0]),
    .rd_data (cur_word),
    .wr_en   (mem_wr),
    .wr_addr (st_r[ST_AW-1:0]),
    .wr_data (new_word)
  );

  // modify step
  plca_timer_update u_upd (
    .cmd      (cmd_r),
    .st       (st_r),
    .id       (id_r),
    .cur      (cur_word),
    .timeouts (timeouts),
    .nxt      (new_word),
    .wr_en    (upd_wr),
    .res      (upd_res)
  );

  // handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign adv         = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign mem_wr      = adv && upd_wr;

  // control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (adv) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.command;
      st_r  <= in_ch.station;
      id_r  <= in_ch.timer_id;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= upd_res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.ok       = res_r.ok;
  assign out_ch.done_res = res_r.done_res;

  // store written back only from the execute step
  a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |-> (state_r == ST_EXEC))
    else $error("store write outside execute step");

  // an accepted item goes to execute next
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted item did not reach execute");

  // finishing execute always leaves a result waiting
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded after execute");

  // a stalled result keeps the next item in execute
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && !out_ch.ready) |=> (state_r == ST_EXEC))
    else $error("execute left while result slot busy");

endmodule
